@@ design/matrix_multiply_with_bias_defines.svh @@
// assertion macros for the matrix multiply with bias block
`ifndef MATRIX_MULTIPLY_WITH_BIAS_DEFINES_SVH
`define MATRIX_MULTIPLY_WITH_BIAS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MMB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MMB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mmb_pkg.sv @@
// shared types, codes and helpers of the matrix multiply with bias block
package mmb_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + 4;
  localparam int FRAC_W    = 16;
  localparam int DIM_W     = 4;
  localparam int FIELD_W   = 3;
  localparam int OP_W      = 2;
  localparam int PADDR_W   = 4;
  localparam int MAX_DIM_D = 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A    = 2'd0,
    OP_LOAD_B    = 2'd1,
    OP_LOAD_BIAS = 2'd2,
    OP_START     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_OUT_ROWS    = 2'd0,
    REG_INNER_SIZE  = 2'd1,
    REG_OUT_COLS    = 2'd2,
    REG_BIAS_ENABLE = 2'd3
  } reg_idx_t;

  // zero counts as one, above the limit saturates
  function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] val, input int max_dim);
    logic [DIM_W-1:0] res;
    res = val;
    if (val == '0) begin
      res = DIM_W'(1);
    end else if (int'(val) > max_dim) begin
      res = DIM_W'(max_dim);
    end
    return res;
  endfunction

endpackage

@@ design/matrix_multiply_with_bias.sv @@
// top level of the matrix multiply with bias block
//
//  channel | handshake        | payload
//  --------+------------------+-------------------------------------------------
//  in      | in_valid/in_stall| operation, row_index, col_index, element_value
//  out     | out_valid/stall  | result_value, result_row, result_col, last_result
//  cfg     | apb psel/penable | out_rows, inner_size, out_cols, bias_enable
//
// a load transfer is taken while the block is idle; a start keeps in_stall high until
// the last result is written back, each result in turn on the single shared
// multiply-accumulate unit: a ram read per inner step, a pipeline drain, a write back
// synchronous active-low reset clears control state and the bias row, a and b
// rams hold garbage until loaded; a stalled result only delays the next write back
// a new item is taken as soon as the last result sits in the output register
module matrix_multiply_with_bias #(
  parameter int MAX_DIM = mmb_pkg::MAX_DIM_D
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mmb_pkg::OP_W-1:0]            in_operation,
  input  logic [mmb_pkg::FIELD_W-1:0]         in_row_index,
  input  logic [mmb_pkg::FIELD_W-1:0]         in_col_index,
  input  logic signed [mmb_pkg::DATA_W-1:0]   in_element_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mmb_pkg::DATA_W-1:0]   out_result_value,
  output logic [mmb_pkg::FIELD_W-1:0]         out_result_row,
  output logic [mmb_pkg::FIELD_W-1:0]         out_result_col,
  output logic                                out_last_result,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mmb_pkg::PADDR_W-1:0]         paddr,
  input  logic [mmb_pkg::DATA_W-1:0]          pwdata,
  output logic [mmb_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  import mmb_pkg::*;

  `include "matrix_multiply_with_bias_defines.svh"

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN
  } state_t;

  // configuration registers
  logic [DIM_W-1:0] out_rows_r, inner_size_r, out_cols_r;
  logic             bias_enable_r;
  logic             cfg_write;
  logic [DIM_W-1:0] r_dim, n_dim, c_dim;

  // sequencer
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             issue;
  logic             init_acc;
  logic             wb;
  logic             wb_last;

  // mac pipeline
  logic                       v1_r, v2_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [DATA_W-1:0]   a_rdata, b_rdata;
  logic signed [DATA_W-1:0]   bias_r [MAX_DIM];
  logic signed [DATA_W-1:0]   bias_sel;
  logic signed [DATA_W-1:0]   sat_val;
  logic                       fits;

  // load side
  logic          in_xfer;
  logic          load_ok;
  logic          a_we, b_we;
  logic [AW-1:0] waddr, a_raddr, b_raddr;
  logic          out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    case (reg_idx_t'(paddr[PADDR_W-1:2]))
      REG_OUT_ROWS:    prdata = DATA_W'(out_rows_r);
      REG_INNER_SIZE:  prdata = DATA_W'(inner_size_r);
      REG_OUT_COLS:    prdata = DATA_W'(out_cols_r);
      REG_BIAS_ENABLE: prdata = DATA_W'(bias_enable_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_rows_r    <= DIM_W'(8);
      inner_size_r  <= DIM_W'(8);
      out_cols_r    <= DIM_W'(8);
      bias_enable_r <= 1'b1;
    end else if (cfg_write) begin
      case (reg_idx_t'(paddr[PADDR_W-1:2]))
        REG_OUT_ROWS:    out_rows_r    <= pwdata[DIM_W-1:0];
        REG_INNER_SIZE:  inner_size_r  <= pwdata[DIM_W-1:0];
        REG_OUT_COLS:    out_cols_r    <= pwdata[DIM_W-1:0];
        REG_BIAS_ENABLE: bias_enable_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign r_dim = dim_of(out_rows_r, MAX_DIM);
  assign n_dim = dim_of(inner_size_r, MAX_DIM);
  assign c_dim = dim_of(out_cols_r, MAX_DIM);

  // loads go straight to the stores, out-of-range indexes are dropped
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid & ~in_stall;
  assign load_ok  = (DIM_W'(in_row_index) < DIM_W'(MAX_DIM)) &&
                    (DIM_W'(in_col_index) < DIM_W'(MAX_DIM));
  assign a_we     = in_xfer && (op_t'(in_operation) == OP_LOAD_A) && load_ok;
  assign b_we     = in_xfer && (op_t'(in_operation) == OP_LOAD_B) && load_ok;
  assign waddr    = AW'(int'(in_row_index) * MAX_DIM + int'(in_col_index));

  // a[i][k] and b[k][j] for the current step
  assign a_raddr = AW'(int'(i_r) * MAX_DIM + int'(k_r));
  assign b_raddr = AW'(int'(k_r) * MAX_DIM + int'(j_r));

  mmb_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mmb_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // bias row lives in flops so reset clears it at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < MAX_DIM; e++) begin
        bias_r[e] <= '0;
      end
    end else if (in_xfer && (op_t'(in_operation) == OP_LOAD_BIAS) &&
                 (DIM_W'(in_col_index) < DIM_W'(MAX_DIM))) begin
      bias_r[in_col_index[IDX_W-1:0]] <= in_element_value;
    end
  end

  // output register is free when empty or being drained this cycle
  assign out_free = ~out_valid | ~out_stall;

  // saturate floor(acc / 2^16) to 32 bits
  assign fits    = (&acc_r[ACC_W-1:FRAC_W+DATA_W-1]) | ~(|acc_r[ACC_W-1:FRAC_W+DATA_W-1]);
  assign sat_val = fits ? acc_r[FRAC_W+DATA_W-1:FRAC_W]
                        : (acc_r[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                          : {1'b0, {(DATA_W-1){1'b1}}});

  // sequencer: walk i, j and k; one mac step per k
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    issue     = 1'b0;
    init_acc  = 1'b0;
    wb        = 1'b0;
    wb_last   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && (op_t'(in_operation) == OP_START)) begin
          state_nxt = S_MAC;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          init_acc  = 1'b1;
        end
      end
      S_MAC: begin
        issue = 1'b1;
        if (DIM_W'(k_r) + DIM_W'(1) == n_dim) begin
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        // accumulator is final once both pipeline stages are empty
        if (!v1_r && !v2_r && out_free) begin
          wb    = 1'b1;
          k_nxt = '0;
          if (DIM_W'(j_r) + DIM_W'(1) == c_dim) begin
            j_nxt = '0;
            if (DIM_W'(i_r) + DIM_W'(1) == r_dim) begin
              wb_last   = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              i_nxt     = i_r + IDX_W'(1);
              state_nxt = S_MAC;
              init_acc  = 1'b1;
            end
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = S_MAC;
            init_acc  = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign bias_sel = bias_enable_r ? bias_r[j_nxt] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      if (wb) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    // payload registers
    if (v1_r) begin
      prod_r <= a_rdata * b_rdata;
    end
    if (init_acc) begin
      acc_r <= {{(ACC_W-DATA_W-FRAC_W){bias_sel[DATA_W-1]}}, bias_sel, {FRAC_W{1'b0}}};
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (wb) begin
      out_result_value <= sat_val;
      out_result_row   <= FIELD_W'(i_r);
      out_result_col   <= FIELD_W'(j_r);
      out_last_result  <= wb_last;
    end
  end

  // checks
  `MMB_ASSERT_NOW(a_idle_empty, clk, rst_n, !in_stall, !v1_r && !v2_r, "mac busy while accepting")
  `MMB_ASSERT_NEXT(a_last_idle, clk, rst_n, wb && wb_last, !in_stall, "last result but busy")
  `MMB_ASSERT_NOW(a_wb_free, clk, rst_n, wb, !v2_r && out_free, "write back before drain")
  `MMB_ASSERT_NEXT(a_start_run, clk, rst_n, in_xfer && (op_t'(in_operation) == OP_START), in_stall, "start did not run")

endmodule

@@ design/mmb_ram.sv @@
// generic simple dual-port ram with registered read
module mmb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
